[rtl/gpg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid potential gradient package
// Shared types and constants for the controller and datapath.
// ----------------------------------------------------------------------------
package gpg_pkg;

  // Grid edge length of the store and width of a stored potential.
  localparam int DIM_MAX     = 16;
  localparam int VALUE_WIDTH = 32;

  typedef enum logic [2:0] {
    REG_PERIODIC = 3'd0,
    REG_SIZE_I   = 3'd1,
    REG_SIZE_J   = 3'd2,
    REG_SIZE_K   = 3'd3,
    REG_RECIP_X  = 3'd4,
    REG_RECIP_Y  = 3'd5,
    REG_RECIP_Z  = 3'd6
  } reg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_MUL,
    ST_SCALE,
    ST_NEXT,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start_query;
    logic       write_node;
    logic       read_tap;
    logic       acc_tap;
    logic       mul;
    logic       scale;
    logic       clr_acc;
    logic       emit;
    logic [1:0] axis;
    logic [1:0] tap;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] num_taps;
  } dp_sts_t;

endpackage
`default_nettype wire

[rtl/grid_potential_gradient.sv]
`timescale 1ns / 1ps
`default_nettype none
// A query steps through READ and WAIT for each tap, then MUL, SCALE and NEXT
// for each axis, taps being the potentials read over all three axes (6 to 9),
// and strobes its result in DONE; no new request is taken until it is idle.
// A load is written at its accepting edge; loads go one per cycle when idle.
// Reset loads register defaults; the grid memory holds no value until written.
// The receiver cannot stall: the result strobe lasts one cycle.
// ----------------------------------------------------------------------------
// Grid potential gradient
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
module grid_potential_gradient
  import gpg_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          operation_i,
  input  wire logic [$clog2(DIM_MAX)-1:0]    node_i_i,
  input  wire logic [$clog2(DIM_MAX)-1:0]    node_j_i,
  input  wire logic [$clog2(DIM_MAX)-1:0]    node_k_i,
  input  wire logic signed [VALUE_WIDTH-1:0] potential_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [2:0]                    cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  output logic                               result_valid_o,
  output logic signed [VALUE_WIDTH-1:0]      field_x_o,
  output logic signed [VALUE_WIDTH-1:0]      field_y_o,
  output logic signed [VALUE_WIDTH-1:0]      field_z_o,
  output logic                               clipped_o
);

  localparam int CW = $clog2(DIM_MAX);
  localparam int SW = CW + 1;

  logic [5:0]  periodic_q;
  logic [SW-1:0] size_q [3];
  logic [31:0] recip_q [3];
  logic [SW-1:0] clamp;
  logic in_grid, go, ctl_busy;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_comb begin
    if (cfg_data_i[4:0] < 5'd3) clamp = SW'(3);
    else if (32'(cfg_data_i[4:0]) > 32'(DIM_MAX)) clamp = SW'(DIM_MAX);
    else clamp = SW'(cfg_data_i[4:0]);
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q <= '0;
      size_q[0]  <= SW'(DIM_MAX);
      size_q[1]  <= SW'(DIM_MAX);
      size_q[2]  <= SW'(DIM_MAX);
      recip_q[0] <= 32'd65536;
      recip_q[1] <= 32'd65536;
      recip_q[2] <= 32'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_PERIODIC: periodic_q <= cfg_data_i[5:0];
        REG_SIZE_I:   size_q[0]  <= clamp;
        REG_SIZE_J:   size_q[1]  <= clamp;
        REG_SIZE_K:   size_q[2]  <= clamp;
        REG_RECIP_X:  recip_q[0] <= cfg_data_i;
        REG_RECIP_Y:  recip_q[1] <= cfg_data_i;
        REG_RECIP_Z:  recip_q[2] <= cfg_data_i;
        default:      periodic_q <= periodic_q;
      endcase
    end
  end

  assign in_grid = ({1'b0, node_i_i} < size_q[0]) && ({1'b0, node_j_i} < size_q[1])
                && ({1'b0, node_k_i} < size_q[2]);
  assign go = start && !busy && (operation_i == OP_LOAD || in_grid);
  assign busy = ctl_busy;

  gpg_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .query_i (operation_i == OP_QUERY),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (ctl_busy)
  );

  gpg_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .ni_i       (node_i_i),
    .nj_i       (node_j_i),
    .nk_i       (node_k_i),
    .pot_i      (potential_i),
    .periodic_i (periodic_q),
    .size_i_i   (size_q[0]),
    .size_j_i   (size_q[1]),
    .size_k_i   (size_q[2]),
    .recip_x_i  (recip_q[0]),
    .recip_y_i  (recip_q[1]),
    .recip_z_i  (recip_q[2]),
    .sts_o      (sts),
    .fx_o       (field_x_o),
    .fy_o       (field_y_o),
    .fz_o       (field_z_o),
    .clip_o     (clipped_o)
  );

  assign result_valid_o = cmd.emit;

endmodule
`default_nettype wire

[rtl/gpg_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid potential gradient controller
// Sequences load writes, stencil reads, scaling and the result strobe.
// ----------------------------------------------------------------------------
module gpg_ctrl
  import gpg_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    go_i,
  input  wire logic    query_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o,
  output logic         busy_o
);

  state_e     state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [1:0] tap_q, tap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= '0;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      tap_q   <= tap_d;
    end
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    tap_d   = tap_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i && query_i) begin
          state_d = ST_READ;
          axis_d  = 2'd0;
          tap_d   = 2'd0;
        end
      end
      ST_READ: state_d = ST_WAIT;
      ST_WAIT: begin
        if (tap_q == sts_i.num_taps - 2'd1) begin
          state_d = ST_MUL;
        end else begin
          tap_d   = tap_q + 2'd1;
          state_d = ST_READ;
        end
      end
      ST_MUL:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_NEXT;
      ST_NEXT: begin
        tap_d = 2'd0;
        if (axis_q == 2'd2) begin
          state_d = ST_DONE;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_READ;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.axis        = axis_q;
    cmd_o.tap         = tap_q;
    cmd_o.start_query = (state_q == ST_IDLE) && go_i && query_i;
    cmd_o.write_node  = (state_q == ST_IDLE) && go_i && !query_i;
    busy_o            = (state_q != ST_IDLE);
    unique case (state_q)
      ST_READ:  cmd_o.read_tap = 1'b1;
      ST_WAIT:  cmd_o.acc_tap  = 1'b1;
      ST_MUL:   cmd_o.mul      = 1'b1;
      ST_SCALE: cmd_o.scale    = 1'b1;
      ST_NEXT:  cmd_o.clr_acc  = 1'b1;
      ST_DONE:  cmd_o.emit     = 1'b1;
      default:  cmd_o.clr_acc  = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/gpg_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid potential gradient datapath
// Grid memory, stencil accumulator, split multiplier and saturation.
// ----------------------------------------------------------------------------
module gpg_dpath
  import gpg_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dp_cmd_t                       cmd_i,
  input  wire logic [$clog2(DIM_MAX)-1:0]    ni_i,
  input  wire logic [$clog2(DIM_MAX)-1:0]    nj_i,
  input  wire logic [$clog2(DIM_MAX)-1:0]    nk_i,
  input  wire logic signed [VALUE_WIDTH-1:0] pot_i,
  input  wire logic [5:0]                    periodic_i,
  input  wire logic [$clog2(DIM_MAX):0]      size_i_i,
  input  wire logic [$clog2(DIM_MAX):0]      size_j_i,
  input  wire logic [$clog2(DIM_MAX):0]      size_k_i,
  input  wire logic [31:0]                   recip_x_i,
  input  wire logic [31:0]                   recip_y_i,
  input  wire logic [31:0]                   recip_z_i,
  output dp_sts_t                            sts_o,
  output logic signed [VALUE_WIDTH-1:0]      fx_o,
  output logic signed [VALUE_WIDTH-1:0]      fy_o,
  output logic signed [VALUE_WIDTH-1:0]      fz_o,
  output logic                               clip_o
);

  localparam int CW    = $clog2(DIM_MAX);
  localparam int SW    = CW + 1;
  localparam int AW    = 3 * CW;
  localparam int DEPTH = DIM_MAX * DIM_MAX * DIM_MAX;
  localparam int ACCW  = VALUE_WIDTH + 4;
  localparam int PW    = 26 + 32;
  localparam int HW    = ACCW - 26 + 32;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_q;

  logic [CW-1:0] ci_q, cj_q, ck_q;
  logic signed [ACCW-1:0] acc_q;
  logic signed [3:0] coef_q;
  logic [PW-1:0] plo_q;
  logic [HW-1:0] phi_q;
  logic neg_q;
  logic signed [VALUE_WIDTH-1:0] f_q [3];
  logic clip_q;

  logic [CW-1:0] p;
  logic [SW-1:0] n;
  logic pmin, pmax;
  logic [SW-1:0] pos_w;
  logic signed [3:0] coef_w;
  logic [1:0] ntaps;
  logic [CW-1:0] ti, tj, tk;
  logic [31:0] recip;

  always_comb begin
    unique case (cmd_i.axis)
      2'd1:    begin p = cj_q; n = size_j_i; recip = recip_y_i; end
      2'd2:    begin p = ck_q; n = size_k_i; recip = recip_z_i; end
      default: begin p = ci_q; n = size_i_i; recip = recip_x_i; end
    endcase
    pmin   = periodic_i[{cmd_i.axis, 1'b0}];
    pmax   = periodic_i[{cmd_i.axis, 1'b1}];
    pos_w  = '0;
    coef_w = '0;
    if ({1'b0, p} == SW'(0) && !pmin) begin
      ntaps = 2'd3;
      pos_w = SW'(cmd_i.tap);
      coef_w = (cmd_i.tap == 2'd0) ? -4'sd3 : (cmd_i.tap == 2'd1) ? 4'sd4 : -4'sd1;
    end else if ({1'b0, p} == n - SW'(1) && !pmax) begin
      ntaps = 2'd3;
      pos_w = n - SW'(3) + SW'(cmd_i.tap);
      coef_w = (cmd_i.tap == 2'd0) ? 4'sd1 : (cmd_i.tap == 2'd1) ? -4'sd4 : 4'sd3;
    end else if ({1'b0, p} == SW'(0) || {1'b0, p} == n - SW'(1)) begin
      ntaps = 2'd2;
      pos_w = (cmd_i.tap == 2'd0) ? SW'(1) : n - SW'(2);
      coef_w = (cmd_i.tap == 2'd0) ? 4'sd1 : -4'sd1;
    end else begin
      ntaps = 2'd2;
      pos_w = (cmd_i.tap == 2'd0) ? {1'b0, p} + SW'(1) : {1'b0, p} - SW'(1);
      coef_w = (cmd_i.tap == 2'd0) ? 4'sd1 : -4'sd1;
    end
    ti = ci_q; tj = cj_q; tk = ck_q;
    unique case (cmd_i.axis)
      2'd1:    tj = pos_w[CW-1:0];
      2'd2:    tk = pos_w[CW-1:0];
      default: ti = pos_w[CW-1:0];
    endcase
  end

  assign sts_o.num_taps = ntaps;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_node) begin
      mem[{ni_i, nj_i, nk_i}] <= pot_i;
    end
    if (cmd_i.read_tap) begin
      rd_q <= mem[AW'({ti, tj, tk})];
    end
  end

  logic [ACCW-1:0] mag;
  logic [HW-1:0] lim;
  logic [HW-1:0] res;
  logic over;

  always_comb begin
    mag = acc_q[ACCW-1] ? ACCW'(-acc_q) : ACCW'(acc_q);
    lim = (acc_q > 0) ? HW'(1) << (VALUE_WIDTH - 1)
                      : (HW'(1) << (VALUE_WIDTH - 1)) - HW'(1);
    over = (phi_q > (lim >> 10) + HW'(1));
    res = (phi_q << 10) + HW'((plo_q + PW'(16'h8000)) >> 16);
    if (!over && res > lim) over = 1'b1;
    if (over) res = lim;
    if (neg_q) res = -res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      clip_q <= 1'b0;
      coef_q <= '0;
    end else begin
      if (cmd_i.start_query) begin
        acc_q  <= '0;
        clip_q <= 1'b0;
      end
      if (cmd_i.read_tap) coef_q <= coef_w;
      if (cmd_i.acc_tap) begin
        acc_q <= acc_q + ACCW'($signed(rd_q)) * ACCW'(coef_q);
      end
      if (cmd_i.scale) clip_q <= clip_q | over;
      if (cmd_i.clr_acc) acc_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_query) begin
      ci_q <= ni_i;
      cj_q <= nj_i;
      ck_q <= nk_i;
    end
    if (cmd_i.mul) begin
      neg_q <= (acc_q > 0);
      plo_q <= PW'(mag[25:0]) * PW'(recip);
      phi_q <= HW'(mag >> 26) * HW'(recip);
    end
    if (cmd_i.scale) begin
      f_q[cmd_i.axis] <= res[VALUE_WIDTH-1:0];
    end
  end

  assign fx_o   = f_q[0];
  assign fy_o   = f_q[1];
  assign fz_o   = f_q[2];
  assign clip_o = clip_q;

endmodule
`default_nettype wire

[rtl/gpg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid potential gradient checker
// Port-level checks on the request and result timing.
// ----------------------------------------------------------------------------
module gpg_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid_i
);

  a_strobe_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |=> !result_valid_i) else $error("strobe longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> busy) else $error("result while idle");

  a_strobe_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |=> !busy) else $error("busy after result");

  a_no_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_i) else $error("result too early");

endmodule

bind grid_potential_gradient gpg_checker u_gpg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_i (result_valid_o)
);
`default_nettype wire

[sim/grid_potential_gradient_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid potential gradient testbench
// Loads potentials into small boxes of the grid and queries the field at
// their nodes under many wall, size and spacing settings. The expected field
// of every in-grid query is computed alongside and checked against its strobe.
// ----------------------------------------------------------------------------
module grid_potential_gradient_tb;
  import gpg_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;

  typedef struct {
    op_e               op;
    logic [3:0]        ni;
    logic [3:0]        nj;
    logic [3:0]        nk;
    logic signed [31:0] pot;
  } grid_req_t;

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic               clip;
  } field_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               operation_i = OP_LOAD;
  logic [3:0]         node_i_i = '0;
  logic [3:0]         node_j_i = '0;
  logic [3:0]         node_k_i = '0;
  logic signed [31:0] potential_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               result_valid_o;
  logic signed [31:0] field_x_o;
  logic signed [31:0] field_y_o;
  logic signed [31:0] field_z_o;
  logic               clipped_o;

  grid_req_t          pending_reqs[$];
  field_t             field_expected[$];
  int                 errors = 0;
  int                 cycles = 0;
  int                 gap_left = 0;
  int                 burst_left = 5;

  logic signed [31:0] grid_mem[4096];
  bit                 grid_set[4096];
  logic [5:0]         wrap_faces;
  int                 axis_size[3];
  logic [31:0]        axis_recip[3];

  grid_potential_gradient uut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .node_i_i, .node_j_i, .node_k_i,
    .potential_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .field_x_o, .field_y_o, .field_z_o, .clipped_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int node_addr(int c[3]);
    return c[0] * 256 + c[1] * 16 + c[2];
  endfunction

  function automatic longint node_at(int c[3], int ax, int pos, inout bit ok);
    int t[3];
    t = c;
    t[ax] = pos;
    if (!grid_set[node_addr(t)]) ok = 1'b0;
    return longint'(grid_mem[node_addr(t)]);
  endfunction

  function automatic longint axis_delta(int c[3], int ax, inout bit ok);
    int  p;
    int  n;
    bit  pmin;
    bit  pmax;
    p = c[ax];
    n = axis_size[ax];
    pmin = wrap_faces[2 * ax];
    pmax = wrap_faces[2 * ax + 1];
    if (p == 0 && !pmin)
      return -3 * node_at(c, ax, 0, ok) + 4 * node_at(c, ax, 1, ok) - node_at(c, ax, 2, ok);
    if (p == n - 1 && !pmax)
      return node_at(c, ax, n - 3, ok) - 4 * node_at(c, ax, n - 2, ok)
             + 3 * node_at(c, ax, n - 1, ok);
    if (p == 0 || p == n - 1)
      return node_at(c, ax, 1, ok) - node_at(c, ax, n - 2, ok);
    return node_at(c, ax, p + 1, ok) - node_at(c, ax, p - 1, ok);
  endfunction

  function automatic logic [31:0] scale_delta(longint d, logic [31:0] r, inout bit clip);
    logic [63:0] mag;
    logic [63:0] lim;
    logic [63:0] plo;
    logic [63:0] phi;
    logic [63:0] res;
    bit          neg;
    neg = d > 0;
    mag = (d < 0) ? -d : d;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    plo = (mag & 64'h3ff_ffff) * {32'h0, r};
    phi = (mag >> 26) * {32'h0, r};
    if (phi > (lim >> 10) + 1) begin
      res = lim;
      clip = 1'b1;
    end else begin
      res = (phi << 10) + ((plo + 64'h8000) >> 16);
      if (res > lim) begin
        res = lim;
        clip = 1'b1;
      end
    end
    if (neg) res = -res;
    return res[31:0];
  endfunction

  // Queues a request and predicts its effect; a query that would read an
  // unloaded node is dropped.
  task automatic issue(op_e op, int i, int j, int k, logic signed [31:0] pot);
    grid_req_t req;
    field_t    f;
    int        c[3];
    bit        ok;
    bit        clip;
    c[0] = i;
    c[1] = j;
    c[2] = k;
    req.op = op;
    req.ni = 4'(i);
    req.nj = 4'(j);
    req.nk = 4'(k);
    req.pot = pot;
    if (op == OP_LOAD) begin
      grid_mem[node_addr(c)] = pot;
      grid_set[node_addr(c)] = 1'b1;
      pending_reqs = {pending_reqs, req};
    end else if (i >= axis_size[0] || j >= axis_size[1] || k >= axis_size[2]) begin
      pending_reqs = {pending_reqs, req};
    end else begin
      ok = 1'b1;
      clip = 1'b0;
      f.fx = scale_delta(axis_delta(c, 0, ok), axis_recip[0], clip);
      f.fy = scale_delta(axis_delta(c, 1, ok), axis_recip[1], clip);
      f.fz = scale_delta(axis_delta(c, 2, ok), axis_recip[2], clip);
      f.clip = clip;
      if (ok) begin
        pending_reqs = {pending_reqs, req};
        field_expected = {field_expected, f};
      end
    end
  endtask

  function automatic logic [31:0] pick_potential();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_recip();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h0001_0000;
      3: return $urandom_range(1, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || field_expected.size() != 0 || start || busy)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [31:0] data);
    int v;
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    v = data & 31;
    if (v < 3) v = 3;
    if (v > 16) v = 16;
    case (idx)
      REG_PERIODIC: wrap_faces = data[5:0];
      REG_SIZE_I:   axis_size[0] = v;
      REG_SIZE_J:   axis_size[1] = v;
      REG_SIZE_K:   axis_size[2] = v;
      REG_RECIP_X:  axis_recip[0] = data;
      REG_RECIP_Y:  axis_recip[1] = data;
      REG_RECIP_Z:  axis_recip[2] = data;
      default: ;
    endcase
  endtask

  task automatic setup(logic [5:0] faces, int si, int sj, int sk,
                       logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
    reg_write(REG_PERIODIC, {26'h0, faces});
    reg_write(REG_SIZE_I, si);
    reg_write(REG_SIZE_J, sj);
    reg_write(REG_SIZE_K, sk);
    reg_write(REG_RECIP_X, rx);
    reg_write(REG_RECIP_Y, ry);
    reg_write(REG_RECIP_Z, rz);
  endtask

  task automatic fill_box(int ni, int nj, int nk);
    int c[3];
    for (int i = 0; i < ni; i++)
      for (int j = 0; j < nj; j++)
        for (int k = 0; k < nk; k++) begin
          c[0] = i;
          c[1] = j;
          c[2] = k;
          if (!grid_set[node_addr(c)]) issue(OP_LOAD, i, j, k, pick_potential());
        end
  endtask

  task automatic query_box(int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        for (int k = 0; k < n; k++)
          issue(OP_QUERY, i, j, k, $urandom);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        void'(pending_reqs.pop_front());
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end else begin
          burst_left--;
        end
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        operation_i <= pending_reqs[0].op;
        node_i_i <= pending_reqs[0].ni;
        node_j_i <= pending_reqs[0].nj;
        node_k_i <= pending_reqs[0].nk;
        potential_i <= pending_reqs[0].pot;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (field_expected.size() == 0) begin
        $error("unexpected result strobe");
        errors++;
      end else begin
        field_t f;
        f = field_expected.pop_front();
        if (field_x_o !== f.fx) begin
          $error("field_x expected %0d actual %0d", f.fx, field_x_o);
          errors++;
        end
        if (field_y_o !== f.fy) begin
          $error("field_y expected %0d actual %0d", f.fy, field_y_o);
          errors++;
        end
        if (field_z_o !== f.fz) begin
          $error("field_z expected %0d actual %0d", f.fz, field_z_o);
          errors++;
        end
        if (clipped_o !== f.clip) begin
          $error("clipped expected %0b actual %0b", f.clip, clipped_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int si;
    int sj;
    int sk;
    wrap_faces = '0;
    axis_size = '{16, 16, 16};
    axis_recip = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
    foreach (grid_set[a]) grid_set[a] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: corner box with full-scale values, queries near the origin.
    issue(OP_LOAD, 0, 0, 0, 32'h7fff_ffff);
    issue(OP_LOAD, 1, 0, 0, 32'h8000_0000);
    issue(OP_LOAD, 2, 0, 0, 32'h7fff_ffff);
    issue(OP_LOAD, 15, 15, 15, 32'h8000_0000);
    fill_box(3, 3, 3);
    query_box(3);
    drain();

    // Out-of-range sizes saturate, all walls periodic, extreme spacings.
    setup(6'h3f, 0, 1, 31, 32'hffff_ffff, 32'h0, 32'h1);
    fill_box(3, 3, 16);
    query_box(3);
    issue(OP_QUERY, 3, 0, 0, 0);
    issue(OP_QUERY, 0, 3, 15, 0);
    issue(OP_QUERY, 1, 1, 15, 0);
    drain();
    setup(6'h00, 2, 3, 3, 32'h0001_0000, 32'hffff_ffff, 32'h0);
    query_box(3);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      si = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      sj = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      sk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      if (ph == 5) si = $urandom_range(16, 31);
      setup(6'($urandom_range(0, 63)), si, sj, sk, pick_recip(), pick_recip(),
            pick_recip());
      fill_box(axis_size[0], axis_size[1], axis_size[2]);
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2:
            issue(OP_LOAD, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), pick_potential());
          3:
            issue(OP_QUERY, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom);
          default:
            issue(OP_QUERY, $urandom_range(0, axis_size[0] - 1),
                  $urandom_range(0, axis_size[1] - 1),
                  $urandom_range(0, axis_size[2] - 1), $urandom);
        endcase
      end
      drain();
    end

    if (field_expected.size() != 0) begin
      $error("%0d results never arrived", field_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/gpg_pkg.sv
rtl/gpg_ctrl.sv
rtl/gpg_dpath.sv
rtl/grid_potential_gradient.sv
rtl/gpg_checker.sv
sim/grid_potential_gradient_tb.sv
